FILE: hdl/dnsqp_pkg.sv
package dnsqp_pkg;

  // one result item as it travels from the parser to the output stage
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_char;
    logic [2:0]  status;
    logic [15:0] message_id;
    logic [15:0] question_type;
  } item_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 8 + 3 + 16 + 16;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

FILE: hdl/dnsqp_front.sv
module dnsqp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 push_o,
  output dnsqp_pkg::item_t     item_o
);
  import dnsqp_pkg::*;

  localparam logic [3:0] HDR_LEN     = 4'd12;
  localparam logic [2:0] TRAILER_LEN = 3'd4;
  localparam logic [7:0] PTR_MASK    = 8'hc0;
  localparam logic [7:0] DOT_CHAR    = 8'h2e;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_NOQ   = 3'd2;
  localparam logic [2:0] ST_COMP  = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_LABEL   = 6'b000100,
    PH_TRAILER = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_ERROR   = 6'b100000
  } phase_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [15:0] id_r, id_nxt;
  logic        qpres_r, qpres_nxt;
  logic [5:0]  lrem_r, lrem_nxt;
  logic        started_r, started_nxt;
  logic [2:0]  tidx_r, tidx_nxt;
  logic [15:0] qtype_r, qtype_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        accept;
  logic        emit;
  logic [7:0]  ch;
  logic [2:0]  st;

  assign accept = in_valid_i && in_ready_i;

  always_comb begin
    phase_nxt   = phase_r;
    hidx_nxt    = hidx_r;
    id_nxt      = id_r;
    qpres_nxt   = qpres_r;
    lrem_nxt    = lrem_r;
    started_nxt = started_r;
    tidx_nxt    = tidx_r;
    qtype_nxt   = qtype_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    ch          = 8'h00;
    case (phase_r)
      PH_HEADER: begin
        if (hidx_r == 4'd0) begin
          id_nxt = {in_byte_i, 8'h00};
        end else if (hidx_r == 4'd1) begin
          id_nxt = id_r | {8'h00, in_byte_i};
        end else if ((hidx_r == 4'd4 || hidx_r == 4'd5) && in_byte_i != 8'h00) begin
          qpres_nxt = 1'b1;
        end
        hidx_nxt = hidx_r + 4'd1;
        if (hidx_nxt >= HDR_LEN) begin
          if (qpres_nxt) begin
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_NOQ;
          end
        end
      end
      PH_LEN: begin
        if (in_byte_i == 8'h00) begin
          phase_nxt = PH_TRAILER;
          tidx_nxt  = 3'd0;
        end else if ((in_byte_i & PTR_MASK) != 8'h00) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_COMP;
        end else begin
          if (started_r) begin
            emit = 1'b1;
            ch   = DOT_CHAR;
          end
          started_nxt = 1'b1;
          lrem_nxt    = in_byte_i[5:0];
          phase_nxt   = PH_LABEL;
        end
      end
      PH_LABEL: begin
        emit     = 1'b1;
        ch       = fold_lower(in_byte_i);
        lrem_nxt = lrem_r - 6'd1;
        if (lrem_nxt == 6'd0) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_TRAILER: begin
        if (tidx_r == 3'd0) begin
          qtype_nxt = {in_byte_i, 8'h00};
        end else if (tidx_r == 3'd1) begin
          qtype_nxt = qtype_r | {8'h00, in_byte_i};
        end
        tidx_nxt = tidx_r + 3'd1;
        if (tidx_nxt >= TRAILER_LEN) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    case (phase_nxt)
      PH_HEADER:  st = ST_SHORT;
      PH_DONE:    st = ST_OK;
      PH_LEN,
      PH_LABEL,
      PH_TRAILER: st = ST_TRUNC;
      default:    st = err_nxt;
    endcase
  end

  always_comb begin
    item_o = '0;
    if (in_last_i) begin
      item_o.result_kind   = 1'b1;
      item_o.status        = st;
      item_o.message_id    = (st == ST_SHORT) ? 16'h0000 : id_nxt;
      item_o.question_type = (st == ST_OK) ? qtype_nxt : 16'h0000;
    end else begin
      item_o.name_char = ch;
    end
  end

  assign push_o = accept && (in_last_i || emit);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_i)) begin
      phase_r   <= PH_HEADER;
      hidx_r    <= 4'd0;
      id_r      <= 16'h0000;
      qpres_r   <= 1'b0;
      lrem_r    <= 6'd0;
      started_r <= 1'b0;
      tidx_r    <= 3'd0;
      qtype_r   <= 16'h0000;
      err_r     <= ST_OK;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hidx_r    <= hidx_nxt;
      id_r      <= id_nxt;
      qpres_r   <= qpres_nxt;
      lrem_r    <= lrem_nxt;
      started_r <= started_nxt;
      tidx_r    <= tidx_nxt;
      qtype_r   <= qtype_nxt;
      err_r     <= err_nxt;
    end
  end

  // the header counter stops at the header length
  a_hidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hidx_r <= HDR_LEN)
    else $error("header index past header length");

  // a final byte always returns the parser to the start of a message
  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_i |=> phase_r == PH_HEADER && hidx_r == 4'd0 && !started_r)
    else $error("parser did not restart after final byte");

endmodule

FILE: hdl/dnsqp_fifo.sv
module dnsqp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  dnsqp_pkg::item_t  push_item_i,
  output logic              not_full_o,
  input  logic              pop_i,
  output logic              not_empty_o,
  output dnsqp_pkg::item_t  pop_item_o
);
  import dnsqp_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign not_full_o  = count_r != FIFO_CW'(FIFO_DEPTH);
  assign not_empty_o = count_r != '0;
  assign pop_item_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_r <= count_r + FIFO_CW'(1);
        2'b01:   count_r <= count_r - FIFO_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> count_r != FIFO_CW'(FIFO_DEPTH))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

FILE: hdl/dnsqp_back.sv
module dnsqp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty_i,
  input  dnsqp_pkg::item_t                    q_item_i,
  output logic                                q_pop_o,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dnsqp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tuser
);
  import dnsqp_pkg::*;

  logic  out_valid_r;
  item_t out_item_r;
  logic  take;

  assign take    = !out_valid_r || out_tready;
  assign q_pop_o = q_not_empty_i && take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= q_not_empty_i;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      out_item_r <= q_item_i;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.result_kind;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0),
                       out_item_r.question_type,
                       out_item_r.message_id,
                       out_item_r.status,
                       out_item_r.name_char};

endmodule

FILE: hdl/dns_question_parser.sv
// channel   dir  tdata fields (low bit up)                         tuser / tlast
// in_       in   data_byte[7:0]                                    tlast = end_of_message
// out_      out  name_char[7:0] status[10:8] message_id[26:11]     tuser = result_kind
//                question_type[42:27], zero fill to 48 bits
//
// one input byte per cycle while the result queue has room; the parser state updates in the accept cycle
// a result reaches out_ through the queue write, then the output register
// reset (rst_n low, synchronous) empties the queue and output register and restarts
// the parser at the header
// in_tready drops only while the four-entry result queue is full, so out_ stalls
// reach the input once five results are pending (four queued, one in the output register)
module dns_question_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  // input bytes
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dnsqp_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_byte[7:0]
  input  logic                                in_tlast,   // end_of_message
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dnsqp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // name_char, status, message_id,
                                                          // question_type
  output logic                                out_tuser   // result_kind
);
  import dnsqp_pkg::*;

  // front to queue
  logic  push;
  item_t push_item;
  logic  q_not_full;

  // queue to back
  logic  q_not_empty;
  item_t q_item;
  logic  q_pop;

  // the parser only takes a byte when the queue has room for what it may produce
  assign in_tready = q_not_full;

  dnsqp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_i (q_not_full),
    .in_byte_i  (in_tdata),
    .in_last_i  (in_tlast),
    .push_o     (push),
    .item_o     (push_item)
  );

  // short queue decoupling the parser from the output side
  dnsqp_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .not_full_o  (q_not_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_item_o  (q_item)
  );

  // output register and field packing
  dnsqp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty_i (q_not_empty),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule

FILE: sim/dns_question_parser_test.sv
`timescale 1ns / 100ps

module dns_question_parser_test;
  import dnsqp_pkg::*;

  localparam int HEADER_BYTES  = 12;
  localparam int TRAILER_BYTES = 4;
  localparam int MAX_LABEL     = 63;
  localparam int RESET_CYCLES  = 11;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_SLACK   = 10;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [7:0] LEN_TYPE_MASK = 8'hc0;
  localparam logic [7:0] DOT_CHAR      = 8'h2e;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_SHORT       = 3'd1;
  localparam logic [2:0] STAT_NO_QUESTION = 3'd2;
  localparam logic [2:0] STAT_COMPRESSED  = 3'd3;
  localparam logic [2:0] STAT_TRUNCATED   = 3'd4;

  typedef enum logic [2:0] {
    P_HEADER, P_NAME_LEN, P_LABEL, P_TRAILER, P_DONE, P_ERROR
  } parse_phase_e;

  typedef enum {
    MSG_GOOD, MSG_CUT, MSG_POINTER, MSG_NO_QUESTION, MSG_SHORT, MSG_NOISE
  } msg_flavor_e;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // data_byte[7:0]
  logic                   in_tlast;   // end_of_message
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // name_char, status, message_id, question_type
  logic                   out_tuser;  // result_kind

  dns_question_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // parser mirror state
  parse_phase_e m_phase;
  logic [3:0]   hdr_idx;
  logic [15:0]  id_reg;
  logic         has_question;
  logic [5:0]   label_left;
  logic         name_open;
  logic [2:0]   trl_idx;
  logic [15:0]  qtype_reg;
  logic [2:0]   err_code;

  item_t      due_results[$];
  logic [7:0] msg_buf[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int messages_sent  = 0;
  int bytes_sent     = 0;
  int chars_seen     = 0;
  int status_hits[5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_parser();
    m_phase      = P_HEADER;
    hdr_idx      = '0;
    id_reg       = '0;
    has_question = 1'b0;
    label_left   = '0;
    name_open    = 1'b0;
    trl_idx      = '0;
    qtype_reg    = '0;
    err_code     = STAT_OK;
  endfunction

  // advance the mirror by one accepted byte and queue what it produces
  function automatic void parse_question_byte(logic [7:0] b, logic eom);
    item_t      r;
    logic       emit;
    logic [7:0] ch;
    logic [2:0] st;
    emit = 1'b0;
    ch   = 8'h00;
    r    = '0;
    case (m_phase)
      P_HEADER: begin
        if (hdr_idx == 4'd0) id_reg = {b, 8'h00};
        else if (hdr_idx == 4'd1) id_reg[7:0] = b;
        else if ((hdr_idx == 4'd4 || hdr_idx == 4'd5) && b != 8'h00) has_question = 1'b1;
        hdr_idx = hdr_idx + 4'd1;
        if (hdr_idx >= HEADER_BYTES) begin
          if (has_question) begin
            m_phase = P_NAME_LEN;
          end else begin
            m_phase  = P_ERROR;
            err_code = STAT_NO_QUESTION;
          end
        end
      end
      P_NAME_LEN: begin
        if (b == 8'h00) begin
          m_phase = P_TRAILER;
          trl_idx = '0;
        end else if ((b & LEN_TYPE_MASK) != 8'h00) begin
          m_phase  = P_ERROR;
          err_code = STAT_COMPRESSED;
        end else begin
          // dot goes out ahead of every label but the first
          if (name_open) begin
            emit = 1'b1;
            ch   = DOT_CHAR;
          end
          name_open  = 1'b1;
          label_left = b[5:0];
          m_phase    = P_LABEL;
        end
      end
      P_LABEL: begin
        emit = 1'b1;
        ch   = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
        label_left = label_left - 6'd1;
        if (label_left == 6'd0) m_phase = P_NAME_LEN;
      end
      P_TRAILER: begin
        if (trl_idx == 3'd0) qtype_reg = {b, 8'h00};
        else if (trl_idx == 3'd1) qtype_reg[7:0] = b;
        trl_idx = trl_idx + 3'd1;
        if (trl_idx >= TRAILER_BYTES) m_phase = P_DONE;
      end
      default: ;
    endcase

    // the last byte yields only the summary, never its own character
    if (eom) begin
      case (m_phase)
        P_HEADER:                       st = STAT_SHORT;
        P_DONE:                         st = STAT_OK;
        P_NAME_LEN, P_LABEL, P_TRAILER: st = STAT_TRUNCATED;
        default:                        st = err_code;
      endcase
      r.result_kind   = 1'b1;
      r.status        = st;
      r.message_id    = (st == STAT_SHORT) ? 16'h0000 : id_reg;
      r.question_type = (st == STAT_OK) ? qtype_reg : 16'h0000;
      due_results = {due_results, r};
      reset_parser();
    end else if (emit) begin
      r.name_char = ch;
      due_results = {due_results, r};
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    // random sender gap ahead of each byte
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_question_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1);
    messages_sent++;
  endtask

  // stop offering and wait out every pending result
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic void load_header(logic [15:0] id, logic [15:0] qdcount);
    msg_buf.delete();
    msg_buf = {msg_buf, id[15:8]};
    msg_buf = {msg_buf, id[7:0]};
    msg_buf = {msg_buf, 8'h01};
    msg_buf = {msg_buf, 8'h00};
    msg_buf = {msg_buf, qdcount[15:8]};
    msg_buf = {msg_buf, qdcount[7:0]};
    repeat (6) msg_buf = {msg_buf, 8'h00};
  endfunction

  function automatic void build_message(msg_flavor_e flavor);
    int         n_labels;
    int         ptr_at;
    int         len;
    int         cut;
    logic [7:0] c;
    msg_buf.delete();
    if (flavor == MSG_NOISE || flavor == MSG_SHORT) begin
      len = (flavor == MSG_SHORT) ? $urandom_range(1, HEADER_BYTES - 1) : $urandom_range(1, 40);
      repeat (len) msg_buf = {msg_buf, 8'($urandom)};
      return;
    end
    repeat (HEADER_BYTES) msg_buf = {msg_buf, 8'($urandom)};
    if (flavor == MSG_NO_QUESTION) begin
      msg_buf[4] = 8'h00;
      msg_buf[5] = 8'h00;
      repeat ($urandom_range(0, 6)) msg_buf = {msg_buf, 8'($urandom)};
      return;
    end
    if (msg_buf[4] == 8'h00 && msg_buf[5] == 8'h00) msg_buf[5] = 8'($urandom_range(1, 255));
    n_labels = $urandom_range(0, 4);
    ptr_at   = (flavor == MSG_POINTER) ? $urandom_range(0, n_labels) : -1;
    for (int i = 0; i <= n_labels; i++) begin
      // pointer or reserved length type in place of a length or the root byte
      if (i == ptr_at) begin
        msg_buf = {msg_buf, {2'($urandom_range(1, 3)), 6'($urandom)}};
        repeat ($urandom_range(0, 4)) msg_buf = {msg_buf, 8'($urandom)};
        return;
      end
      if (i < n_labels) begin
        len = ($urandom_range(0, 19) == 0) ? MAX_LABEL : $urandom_range(1, 12);
        msg_buf = {msg_buf, 8'(len)};
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       c = 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
            1:       c = 8'($urandom_range(8'h61, 8'h7a));
            2:       c = 8'($urandom_range(8'h2d, 8'h39));
            default: c = 8'($urandom);
          endcase
          msg_buf = {msg_buf, c};
        end
      end
    end
    msg_buf = {msg_buf, 8'h00};
    repeat (TRAILER_BYTES) msg_buf = {msg_buf, 8'($urandom)};
    if (flavor == MSG_CUT) begin
      cut = $urandom_range(HEADER_BYTES, msg_buf.size() - 1);
      while (msg_buf.size() > cut) void'(msg_buf.pop_back());
    end else if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) msg_buf = {msg_buf, 8'($urandom)};
    end
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // lone byte, short header with the id forced to zero
    msg_buf.delete();
    msg_buf = {msg_buf, 8'hff};
    send_message();
    // header ending on its twelfth byte counts as truncated
    load_header(16'h8001, 16'h0001);
    send_message();
    // no question, the byte after the header is ignored
    load_header(16'hffff, 16'h0000);
    msg_buf = {msg_buf, 8'h55};
    send_message();
    // "AZ@[z" and "M": folding edges, two labels, type 0x001c, one extra byte
    load_header(16'hffff, 16'h0100);
    msg_buf = {msg_buf, 8'h05, 8'h41, 8'h5a, 8'h40, 8'h5b, 8'h7a, 8'h01, 8'h4d,
               8'h00, 8'h00, 8'h1c, 8'h00, 8'h01, 8'hff};
    send_message();
    // pointer after one label, characters already out stay out
    load_header(16'h0000, 16'h0100);
    msg_buf = {msg_buf, 8'h02, 8'h41, 8'h62, 8'hc0, 8'h12};
    send_message();
    // reserved length type right after the header
    load_header(16'h1234, 16'h0001);
    msg_buf = {msg_buf, 8'h80};
    send_message();
    // message ends on a label byte
    load_header(16'h00ff, 16'h0001);
    msg_buf = {msg_buf, 8'h03, 8'h58, 8'h59, 8'h5a};
    send_message();
    drain();
  endtask

  task automatic test_random_traffic(int byte_budget, int send_pct, int stall_pct);
    int          sent;
    int          r;
    msg_flavor_e flavor;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < byte_budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) flavor = MSG_GOOD;
      else if (r < 75) flavor = MSG_CUT;
      else if (r < 85) flavor = MSG_POINTER;
      else if (r < 90) flavor = MSG_NO_QUESTION;
      else if (r < 95) flavor = MSG_SHORT;
      else flavor = MSG_NOISE;
      build_message(flavor);
      sent += msg_buf.size();
      send_message();
    end
    drain();
  endtask

  // long output hold-off while bytes keep coming, so the result queue fills
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (6) begin
      build_message(MSG_GOOD);
      send_message();
    end
    drain();
  endtask

  // receiver side: hold-off countdown, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    item_t want;
    item_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.result_kind   = out_tuser;
      got.name_char     = out_tdata[7:0];
      got.status        = out_tdata[10:8];
      got.message_id    = out_tdata[26:11];
      got.question_type = out_tdata[42:27];
      if (due_results.size() == 0) begin
        $display("%0t unexpected item: expected none, actual kind %b char %h status %0d id %h type %h",
                 $time, got.result_kind, got.name_char, got.status, got.message_id,
                 got.question_type);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        check_field("name_char", 16'(want.name_char), 16'(got.name_char));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("message_id", want.message_id, got.message_id);
        check_field("question_type", want.question_type, got.question_type);
        if (!got.result_kind) chars_seen++;
        else if (got.status <= STAT_TRUNCATED) status_hits[got.status]++;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout, %0d results still due", $time, due_results.size());
      $display("dns_question_parser_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    reset_parser();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(330, 0, 0);
    test_random_traffic(330, 73, 0);
    test_random_traffic(330, 0, 73);
    test_random_traffic(330, 11, 11);
    test_backpressure();

    $display("%0d messages in %0d bytes, four idling mixes and a %0d-cycle output hold-off",
             messages_sent, bytes_sent, HOLD_CYCLES);
    $display("%0d name chars; summaries ok %0d short %0d no-question %0d compressed %0d truncated %0d",
             chars_seen, status_hits[STAT_OK], status_hits[STAT_SHORT],
             status_hits[STAT_NO_QUESTION], status_hits[STAT_COMPRESSED],
             status_hits[STAT_TRUNCATED]);
    if (errors == 0) begin
      $display("dns_question_parser_test OK");
    end else begin
      $display("dns_question_parser_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: dns_question_parser.f
hdl/dnsqp_pkg.sv
hdl/dnsqp_front.sv
hdl/dnsqp_fifo.sv
hdl/dnsqp_back.sv
hdl/dns_question_parser.sv
sim/dns_question_parser_test.sv
